[rtl/core/bme_pkg.sv]
// Package for the bipartite matching engine: payload words, modes, sizes.
// No dependencies.
package bme_pkg;

   localparam int VARS_DEF   = 16;
   localparam int VALUES_DEF = 32;
   localparam int VAR_W      = 4;
   localparam int DOM_W      = 32;
   localparam int VAL_W      = 5;
   localparam int CNT_W      = 5;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_GREEDY = 2'd1,
      MODE_REPAIR = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [VAR_W-1:0] var_index;
      logic [DOM_W-1:0] domain_bits;
   } req_word_type;

   typedef struct packed {
      logic [VAR_W-1:0] out_var;
      logic             is_matched;
      logic [VAL_W-1:0] matched_value;
      logic [CNT_W-1:0] matching_size;
      logic             last;
   } rsp_word_type;

endpackage

[rtl/core/bipartite_matching_engine_unit.sv]
// Bipartite matching engine: one value a cycle under a state machine.
// A word is accepted when start is high and busy is low; mode 0 writes a
// domain. Modes 1 and 2 scan one candidate value per cycle (greedy: each
// variable in turn; repair: a drop pass over the variables, then a select
// step per variable and, for each unmatched one, a search of scan steps
// plus backtracks and one commit step per path frame), then report one
// word per cycle on rsp_valid, one for each variable.
// The receiver cannot stall. Depends on bme_pkg.
module bipartite_matching_engine_unit
   import bme_pkg::*;
#(
   parameter int VARS   = VARS_DEF,
   parameter int VALUES = VALUES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int VI_W = (VARS > 1) ? $clog2(VARS) : 1;
   localparam int VV_W = (VALUES > 1) ? $clog2(VALUES) : 1;
   localparam int D_W  = $clog2(VARS + 1);
   localparam int C_W  = $clog2(VARS + 1);
   localparam int VC_W = $clog2(VALUES + 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_GREEDY = 8'b0000_0010,
      ST_DROP   = 8'b0000_0100,
      ST_AUGSEL = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_COMMIT = 8'b0010_0000,
      ST_BACK   = 8'b0100_0000,
      ST_REPORT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [VALUES-1:0] dom_ff [VARS];
   logic [VV_W-1:0]   vmatch_ff [VARS];
   logic [VARS-1:0]   vhas_ff;
   logic [VI_W-1:0]   owner_ff [VALUES];
   logic [VALUES-1:0] taken_ff;
   logic [VARS-1:0]   vseen_ff;
   logic [VALUES-1:0] valseen_ff;
   logic [VI_W-1:0]   pvar_ff [VARS];
   logic [VV_W-1:0]   pval_ff [VARS];
   logic [C_W-1:0]    count_ff;
   logic [VI_W-1:0]   k_ff;        // outer variable counter
   logic [VC_W-1:0]   v_ff;        // scan value (may reach VALUES)
   logic [D_W-1:0]    d_ff;        // path depth
   logic              k_end_ff;

   // shared candidate test for the current variable and value
   logic [VI_W-1:0] cur_u;
   logic [VV_W-1:0] cur_v;
   logic            v_ok, in_dom;
   assign cur_u  = (state_ff == ST_GREEDY) ? k_ff : pvar_ff[d_ff[VI_W-1:0]];
   assign cur_v  = v_ff[VV_W-1:0];
   assign v_ok   = (v_ff < VC_W'(VALUES));
   assign in_dom = v_ok && dom_ff[cur_u][cur_v];

   logic k_last;
   assign k_last = (k_ff == VI_W'(VARS - 1));

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            case (mode_type'(req_word.mode))
               MODE_GREEDY: state_in = ST_GREEDY;
               MODE_REPAIR: state_in = ST_DROP;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_GREEDY: if ((!v_ok || (in_dom && !taken_ff[cur_v])) && k_last)
            state_in = ST_REPORT;
         ST_DROP: if (k_last) state_in = ST_AUGSEL;
         ST_AUGSEL: begin
            if (k_end_ff || count_ff == C_W'(VARS)) state_in = ST_REPORT;
            else if (!vhas_ff[k_ff]) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!v_ok) state_in = ST_BACK;
            else if (in_dom && !(vhas_ff[cur_u] && vmatch_ff[cur_u] == cur_v)
                     && !valseen_ff[cur_v]) begin
               if (!taken_ff[cur_v]) state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: if (d_ff == '0) state_in = ST_AUGSEL;
         ST_BACK:   state_in = (d_ff == '0) ? ST_AUGSEL : ST_SCAN;
         ST_REPORT: if (k_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // advance the sequencer and the stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vhas_ff  <= '0;
         taken_ff <= '0;
         count_ff <= '0;
         k_ff     <= '0;
         k_end_ff <= 1'b0;
         v_ff     <= '0;
         d_ff     <= '0;
         vseen_ff <= '0;
         valseen_ff <= '0;
         for (int i = 0; i < VARS; i++) dom_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: if (start) begin
               k_ff <= '0;
               v_ff <= '0;
               k_end_ff <= 1'b0;
               if (req_word.mode == MODE_WRITE && {1'b0, req_word.var_index} < 5'(VARS))
                  dom_ff[req_word.var_index[VI_W-1:0]] <=
                     VALUES'(req_word.domain_bits);
               if (req_word.mode == MODE_GREEDY) begin
                  vhas_ff  <= '0;
                  taken_ff <= '0;
                  count_ff <= '0;
               end
            end
            ST_GREEDY: begin
               if (!v_ok || (in_dom && !taken_ff[cur_v])) begin
                  if (v_ok) begin
                     vmatch_ff[k_ff]  <= cur_v;
                     vhas_ff[k_ff]    <= 1'b1;
                     owner_ff[cur_v]  <= k_ff;
                     taken_ff[cur_v]  <= 1'b1;
                     count_ff         <= count_ff + 1'b1;
                  end
                  k_ff <= k_last ? '0 : k_ff + 1'b1;
                  v_ff <= '0;
               end else v_ff <= v_ff + 1'b1;
            end
            // drop matches whose value left the domain
            ST_DROP: begin
               if (vhas_ff[k_ff] && !dom_ff[k_ff][vmatch_ff[k_ff]]) begin
                  taken_ff[vmatch_ff[k_ff]] <= 1'b0;
                  vhas_ff[k_ff] <= 1'b0;
                  count_ff <= count_ff - 1'b1;
               end
               k_ff <= k_last ? '0 : k_ff + 1'b1;
            end
            // pick the next unmatched root; rewind the counter for the report
            ST_AUGSEL: if (!(k_end_ff || count_ff == C_W'(VARS))) begin
               if (!vhas_ff[k_ff]) begin
                  vseen_ff   <= VARS'(1) << k_ff;
                  valseen_ff <= '0;
                  pvar_ff[0] <= k_ff;
                  d_ff <= '0;
                  v_ff <= '0;
               end
               k_end_ff <= k_last;
               k_ff <= k_last ? '0 : k_ff + 1'b1;
            end else k_ff <= '0;
            ST_SCAN: if (v_ok) begin
               if (in_dom && !(vhas_ff[cur_u] && vmatch_ff[cur_u] == cur_v)
                   && !valseen_ff[cur_v]) begin
                  valseen_ff[cur_v] <= 1'b1;
                  pval_ff[d_ff[VI_W-1:0]] <= cur_v;
                  if (!taken_ff[cur_v]) begin
                     count_ff <= count_ff + 1'b1;
                  end else if (!vseen_ff[owner_ff[cur_v]] &&
                               (d_ff + 1'b1) < D_W'(VARS)) begin
                     vseen_ff[owner_ff[cur_v]] <= 1'b1;
                     d_ff <= d_ff + 1'b1;
                     pvar_ff[VI_W'(d_ff + 1'b1)] <= owner_ff[cur_v];
                     v_ff <= '0;
                  end else v_ff <= v_ff + 1'b1;
               end else v_ff <= v_ff + 1'b1;
            end
            // apply one path frame per cycle, deepest first
            ST_COMMIT: begin
               vmatch_ff[pvar_ff[d_ff[VI_W-1:0]]] <= pval_ff[d_ff[VI_W-1:0]];
               vhas_ff[pvar_ff[d_ff[VI_W-1:0]]]   <= 1'b1;
               owner_ff[pval_ff[d_ff[VI_W-1:0]]]  <= pvar_ff[d_ff[VI_W-1:0]];
               taken_ff[pval_ff[d_ff[VI_W-1:0]]]  <= 1'b1;
               if (d_ff != '0) d_ff <= d_ff - 1'b1;
            end
            ST_BACK: if (d_ff != '0) begin
               d_ff <= d_ff - 1'b1;
               v_ff <= VC_W'(pval_ff[VI_W'(d_ff - 1'b1)]) + 1'b1;
            end
            ST_REPORT: k_ff <= k_last ? '0 : k_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // drive one report word per cycle
   assign rsp_valid = (state_ff == ST_REPORT);
   always_comb begin
      rsp_word.out_var       = VAR_W'(k_ff);
      rsp_word.is_matched    = vhas_ff[k_ff];
      rsp_word.matched_value = vhas_ff[k_ff] ? VAL_W'(vmatch_ff[k_ff]) : '0;
      rsp_word.matching_size = CNT_W'(count_ff);
      rsp_word.last          = k_last;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= C_W'(VARS)) else $error("count overflow");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("report while idle");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      d_ff < D_W'(VARS)) else $error("path too deep");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |=> !busy) else $error("no return to idle");

endmodule
